// ----- rtl/imh_pkg.sv -----
// imh_pkg: sizes, codes and the heap entry type of the indexed min-heap.
// No dependencies; imported by indexed_min_heap.
`timescale 1ns / 1ps

package imh_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int KEY_BITS  = 32;
  localparam int ID_W      = $clog2(MAX_ITEMS);
  localparam int SLOT_W    = $clog2(MAX_ITEMS + 1);

  localparam logic [2:0] ACT_INSERT  = 3'd0;
  localparam logic [2:0] ACT_EXTRACT = 3'd1;
  localparam logic [2:0] ACT_CHANGE  = 3'd2;
  localparam logic [2:0] ACT_REMOVE  = 3'd3;
  localparam logic [2:0] ACT_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [KEY_BITS-1:0] key;
  } entry_t;

endpackage

// ----- rtl/indexed_min_heap.sv -----
// indexed_min_heap: indexed binary min-heap over ids with unsigned keys.
// Depends on imh_pkg (sizes, action and status codes, entry_t).
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    in_action, in_item_id, in_item_key
// out_     output     out_valid / out_stall  out_id, out_key, out_status, out_count
//
// Operation: one item at a time. A rejected or trivial item (error, clear, unknown action)
// goes straight to the result. Insert sifts up, extract sifts down, remove raises the id
// to the root and then extracts it, change-key does that plus the insert; each walks at most
// log2(MAX_ITEMS) heap levels, paced by the single read port of the slot memory.
// Reset: synchronous, active low; clears count, presence bits and the handshakes.
// Stalls: a finished item waits in the output register; the next item is taken meanwhile.

module indexed_min_heap (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_action,
  input  logic [imh_pkg::ID_W-1:0]     in_item_id,
  input  logic [imh_pkg::KEY_BITS-1:0] in_item_key,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [imh_pkg::ID_W-1:0]     out_id,
  output logic [imh_pkg::KEY_BITS-1:0] out_key,
  output logic [1:0]                   out_status,
  output logic [imh_pkg::SLOT_W-1:0]   out_count
);
  import imh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UP, S_UP_CMP, S_RS_POS, S_RS_OWN, S_RAISE, S_RAISE_WR,
    S_POP_A, S_POP_B, S_POP_C, S_DN, S_DN_RD1, S_DN_RD2, S_DN_CMP, S_DN_END, S_FIN
  } state_t;

  // Heap slots hold {id, key}; slot s lives at address s-1.
  entry_t            hp_mem [MAX_ITEMS];
  logic [SLOT_W-1:0] pos_mem [MAX_ITEMS];
  entry_t            hp_rd_r;
  logic [SLOT_W-1:0] pos_rd_r;

  state_t                state_r, state_nxt;
  logic [MAX_ITEMS-1:0]  pv_r, pv_nxt;
  logic [SLOT_W-1:0]     cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]     i_r, i_nxt;
  logic [SLOT_W-1:0]     chi_r, chi_nxt;
  entry_t                top_r, top_nxt;
  entry_t                last_r, last_nxt;
  entry_t                ch_r, ch_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [ID_W-1:0]       id_r, id_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [ID_W-1:0]       res_id_r, res_id_nxt;
  logic [KEY_BITS-1:0]   res_key_r, res_key_nxt;
  logic [1:0]            res_st_r, res_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]       out_id_r, out_id_nxt;
  logic [KEY_BITS-1:0]   out_key_r, out_key_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]     out_count_r, out_count_nxt;

  logic              hp_we;
  logic [ID_W-1:0]   hp_wa, hp_ra;
  entry_t            hp_wd;
  logic              pos_we;
  logic [ID_W-1:0]   pos_wa;
  logic [SLOT_W-1:0] pos_wd;
  logic [SLOT_W:0]   child;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign child    = {i_r, 1'b0};

  always_ff @(posedge clk) begin
    if (hp_we) hp_mem[hp_wa] <= hp_wd;
    hp_rd_r <= hp_mem[hp_ra];
  end

  // Slot lookup is only needed for the id of an incoming item.
  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_r <= pos_mem[in_item_id];
  end

  always_comb begin
    state_nxt      = state_r;
    pv_nxt         = pv_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    chi_nxt        = chi_r;
    top_nxt        = top_r;
    last_nxt       = last_r;
    ch_nxt         = ch_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    key_nxt        = key_r;
    res_id_nxt     = res_id_r;
    res_key_nxt    = res_key_r;
    res_st_nxt     = res_st_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_id_nxt     = out_id_r;
    out_key_nxt    = out_key_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    hp_we          = 1'b0;
    hp_wa          = '0;
    hp_wd          = '0;
    hp_ra          = '0;
    pos_we         = 1'b0;
    pos_wa         = '0;
    pos_wd         = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt      = in_action;
          id_nxt      = in_item_id;
          key_nxt     = in_item_key;
          res_id_nxt  = '0;
          res_key_nxt = '0;
          res_st_nxt  = ST_OK;
          state_nxt   = S_FIN;
          case (in_action)
            ACT_INSERT: begin
              if (pv_r[in_item_id]) begin
                res_st_nxt = ST_PRESENT;
              end else begin
                cnt_nxt   = cnt_r + 1'b1;
                i_nxt     = cnt_r + 1'b1;
                state_nxt = S_UP;
              end
            end
            ACT_EXTRACT: begin
              if (cnt_r == '0) res_st_nxt = ST_EMPTY;
              else state_nxt = S_POP_A;
            end
            ACT_CHANGE, ACT_REMOVE: begin
              if (!pv_r[in_item_id]) res_st_nxt = ST_ABSENT;
              else state_nxt = S_RS_POS;
            end
            ACT_CLEAR: begin
              pv_nxt  = '0;
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      // Sift up: parent moves down while its key is strictly greater.
      S_UP: begin
        if (i_r > SLOT_W'(1)) begin
          hp_ra     = ID_W'((i_r >> 1) - 1'b1);
          state_nxt = S_UP_CMP;
        end else begin
          hp_we = 1'b1; hp_wa = ID_W'(i_r - 1'b1); hp_wd = '{id: id_r, key: key_r};
          pos_we = 1'b1; pos_wa = id_r; pos_wd = i_r;
          pv_nxt[id_r] = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_UP_CMP: begin
        hp_we = 1'b1; hp_wa = ID_W'(i_r - 1'b1);
        pos_we = 1'b1; pos_wd = i_r;
        if (hp_rd_r.key > key_r) begin
          hp_wd  = hp_rd_r;
          pos_wa = hp_rd_r.id;
          i_nxt  = i_r >> 1;
          state_nxt = S_UP;
        end else begin
          hp_wd  = '{id: id_r, key: key_r};
          pos_wa = id_r;
          pv_nxt[id_r] = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_RS_POS: begin
        i_nxt     = pos_rd_r;
        hp_ra     = ID_W'(pos_rd_r - 1'b1);
        state_nxt = S_RS_OWN;
      end
      S_RS_OWN: begin
        top_nxt   = hp_rd_r;
        state_nxt = S_RAISE;
      end
      // Raise the id to the root regardless of keys.
      S_RAISE: begin
        if (i_r > SLOT_W'(1)) begin
          hp_ra     = ID_W'((i_r >> 1) - 1'b1);
          state_nxt = S_RAISE_WR;
        end else begin
          hp_we = 1'b1; hp_wa = '0; hp_wd = top_r;
          pos_we = 1'b1; pos_wa = top_r.id; pos_wd = SLOT_W'(1);
          state_nxt = S_POP_A;
        end
      end
      S_RAISE_WR: begin
        hp_we = 1'b1; hp_wa = ID_W'(i_r - 1'b1); hp_wd = hp_rd_r;
        pos_we = 1'b1; pos_wa = hp_rd_r.id; pos_wd = i_r;
        i_nxt     = i_r >> 1;
        state_nxt = S_RAISE;
      end
      S_POP_A: begin
        hp_ra     = '0;
        state_nxt = S_POP_B;
      end
      S_POP_B: begin
        top_nxt   = hp_rd_r;
        hp_ra     = ID_W'(cnt_r - 1'b1);
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_POP_C;
      end
      S_POP_C: begin
        last_nxt  = hp_rd_r;
        i_nxt     = SLOT_W'(1);
        state_nxt = S_DN;
      end
      // Sift down the former last entry from the root.
      S_DN: begin
        if (child <= {1'b0, cnt_r}) begin
          hp_ra     = ID_W'(child - 1'b1);
          state_nxt = S_DN_RD1;
        end else begin
          state_nxt = S_DN_END;
        end
      end
      S_DN_RD1: begin
        ch_nxt  = hp_rd_r;
        chi_nxt = SLOT_W'(child);
        if (child < {1'b0, cnt_r}) begin
          hp_ra     = ID_W'(child);
          state_nxt = S_DN_RD2;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_RD2: begin
        if (ch_r.key > hp_rd_r.key) begin
          ch_nxt  = hp_rd_r;
          chi_nxt = SLOT_W'(child + 1'b1);
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (last_r.key > ch_r.key) begin
          hp_we = 1'b1; hp_wa = ID_W'(i_r - 1'b1); hp_wd = ch_r;
          pos_we = 1'b1; pos_wa = ch_r.id; pos_wd = i_r;
          i_nxt     = chi_r;
          state_nxt = S_DN;
        end else begin
          state_nxt = S_DN_END;
        end
      end
      S_DN_END: begin
        hp_we = 1'b1; hp_wa = ID_W'(i_r - 1'b1); hp_wd = last_r;
        pos_we = 1'b1; pos_wa = last_r.id; pos_wd = i_r;
        pv_nxt[top_r.id] = 1'b0;
        state_nxt = S_FIN;
        if (op_r == ACT_CHANGE) begin
          cnt_nxt   = cnt_r + 1'b1;
          i_nxt     = cnt_r + 1'b1;
          state_nxt = S_UP;
        end else begin
          res_id_nxt  = top_r.id;
          res_key_nxt = top_r.key;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = res_id_r;
          out_key_nxt    = res_key_r;
          out_status_nxt = res_st_r;
          out_count_nxt  = cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control and result registers; payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pv_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r          <= i_nxt;
    chi_r        <= chi_nxt;
    top_r        <= top_nxt;
    last_r       <= last_nxt;
    ch_r         <= ch_nxt;
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    key_r        <= key_nxt;
    res_id_r     <= res_id_nxt;
    res_key_r    <= res_key_nxt;
    res_st_r     <= res_st_nxt;
    out_id_r     <= out_id_nxt;
    out_key_r    <= out_key_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_id     = out_id_r;
  assign out_key    = out_key_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOT_W'(MAX_ITEMS))
    else $error("heap count above capacity");

  a_count_matches_presence: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(pv_r) == int'(cnt_r)))
    else $error("presence bits disagree with heap count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_CLEAR) |=> (pv_r == '0 && cnt_r == '0))
    else $error("clear left items behind");
`endif

endmodule
